/* rtl/ryp_pkg.sv */
`default_nettype none
package ryp_pkg;

  // source_format register codes
  localparam logic FMT_RGB888 = 1'b0;
  localparam logic FMT_RGB565 = 1'b1;

  // BT.601 studio-range coefficients, magnitudes only (signs are in the sums)
  localparam logic [15:0] CY_R = 16'd66;
  localparam logic [15:0] CY_G = 16'd129;
  localparam logic [15:0] CY_B = 16'd25;
  localparam logic [15:0] CU_R = 16'd38;
  localparam logic [15:0] CU_G = 16'd74;
  localparam logic [15:0] CU_B = 16'd112;
  localparam logic [15:0] CV_R = 16'd112;
  localparam logic [15:0] CV_G = 16'd94;
  localparam logic [15:0] CV_B = 16'd18;

  // rounding term, and rounding plus 128<<8 bias that keeps chroma sums positive
  localparam logic [15:0] ROUND_HALF  = 16'd128;
  localparam logic [15:0] CHROMA_BIAS = 16'd32896;
  localparam logic [8:0]  Y_OFFSET    = 9'd16;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
  } yuv_t;

  // one captured pixel pair
  typedef struct packed {
    logic [23:0] left_pixel;
    logic [23:0] right_pixel;
    logic        right_absent;
  } pair_t;

endpackage
`default_nettype wire

/* rtl/ryp_pair_if.sv */
`default_nettype none
interface ryp_pair_if;
  logic        valid;
  logic        ready;
  logic [23:0] left_pixel;
  logic [23:0] right_pixel;
  logic        right_absent;

  modport source (output valid, output left_pixel, output right_pixel, output right_absent,
                  input ready);
  modport sink   (input valid, input left_pixel, input right_pixel, input right_absent,
                  output ready);
endinterface
`default_nettype wire

/* rtl/ryp_word_if.sv */
`default_nettype none
interface ryp_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] yuyv_word;

  modport source (output valid, output yuyv_word, input ready);
  modport sink   (input valid, input yuyv_word, output ready);
endinterface
`default_nettype wire

/* rtl/ryp_widen.sv */
`default_nettype none
module ryp_widen (
  input  wire logic        fmt_i,
  input  wire logic [23:0] pixel_i,
  output ryp_pkg::rgb_t    rgb_o
);
  import ryp_pkg::*;

  logic [4:0] r5;
  logic [5:0] g6;
  logic [4:0] b5;

  assign r5 = pixel_i[15:11];
  assign g6 = pixel_i[10:5];
  assign b5 = pixel_i[4:0];

  // RGB565 widened by replicating the top bits into the low bits
  always_comb begin
    if (fmt_i == FMT_RGB565) begin
      rgb_o.r = {r5, r5[4:2]};
      rgb_o.g = {g6, g6[5:4]};
      rgb_o.b = {b5, b5[4:2]};
    end else begin
      rgb_o.r = pixel_i[23:16];
      rgb_o.g = pixel_i[15:8];
      rgb_o.b = pixel_i[7:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/ryp_convert.sv */
`default_nettype none
module ryp_convert (
  input  wire ryp_pkg::rgb_t rgb_i,
  output ryp_pkg::yuv_t      yuv_o
);
  import ryp_pkg::*;

  logic [15:0] r16;
  logic [15:0] g16;
  logic [15:0] b16;
  logic [15:0] y_sum;
  logic [15:0] u_sum;
  logic [15:0] v_sum;
  logic [8:0]  y_ext;

  assign r16 = {8'd0, rgb_i.r};
  assign g16 = {8'd0, rgb_i.g};
  assign b16 = {8'd0, rgb_i.b};

  // constant-coefficient sums; chroma bias keeps them non-negative in 16 bits
  assign y_sum = CY_R * r16 + CY_G * g16 + CY_B * b16 + ROUND_HALF;
  assign u_sum = CU_B * b16 + CHROMA_BIAS - CU_R * r16 - CU_G * g16;
  assign v_sum = CV_R * r16 + CHROMA_BIAS - CV_G * g16 - CV_B * b16;

  assign y_ext = {1'b0, y_sum[15:8]} + Y_OFFSET;

  // clamp luma to a byte; chroma is already inside 0..255
  always_comb begin
    yuv_o.y = y_ext[8] ? 8'hFF : y_ext[7:0];
    yuv_o.u = u_sum[15:8];
    yuv_o.v = v_sum[15:8];
  end

endmodule
`default_nettype wire

/* rtl/rgb_pair_to_yuyv_packer.sv */
// Channel  | Dir | Handshake     | Payload
// ---------+-----+---------------+------------------------------------------
// pair_i   | in  | valid / ready | left_pixel[23:0], right_pixel[23:0],
//          |     |               | right_absent
// word_o   | out | valid / ready | yuyv_word[31:0] (Y0, U, Y1, V)
// cfg      | in  | cfg_we_i      | cfg_data_i -> source_format
//
// One pair per cycle sustained while word_o is not stalled; each pair passes
// through the capture register, then conversion into the result register,
// before output valid rises.
// Reset clears the stage valid bits and sets source_format to RGB888.
// A stall on word_o holds the result; the capture stage keeps accepting
// until both registers are full.
`default_nettype none
module rgb_pair_to_yuyv_packer (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic      cfg_data_i,
  ryp_pair_if.sink       pair_i,
  ryp_word_if.source     word_o
);
  import ryp_pkg::*;

  logic  fmt_q;
  logic  cap_valid_q;
  pair_t cap_q;
  logic  out_valid_q;
  logic [31:0] out_word_q;
  logic  advance;
  logic  in_take;
  logic [23:0] right_raw;
  rgb_t  left_rgb;
  rgb_t  right_rgb;
  yuv_t  left_yuv;
  yuv_t  right_yuv;
  logic [8:0] u_pair;
  logic [8:0] v_pair;
  logic [31:0] out_word_d;

  // format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_RGB888;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_data_i;
    end
  end

  // stage control
  assign advance      = !out_valid_q || word_o.ready;
  assign pair_i.ready = !cap_valid_q || advance;
  assign in_take      = pair_i.valid && pair_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pair_i.ready) begin
        cap_valid_q <= pair_i.valid;
      end
      if (advance) begin
        out_valid_q <= cap_valid_q;
      end
    end
  end

  // capture register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cap_q.left_pixel   <= pair_i.left_pixel;
      cap_q.right_pixel  <= pair_i.right_pixel;
      cap_q.right_absent <= pair_i.right_absent;
    end
  end

  // at a line end the right pixel repeats the left one
  assign right_raw = cap_q.right_absent ? cap_q.left_pixel : cap_q.right_pixel;

  ryp_widen u_widen_left  (.fmt_i(fmt_q), .pixel_i(cap_q.left_pixel), .rgb_o(left_rgb));
  ryp_widen u_widen_right (.fmt_i(fmt_q), .pixel_i(right_raw),        .rgb_o(right_rgb));

  ryp_convert u_conv_left  (.rgb_i(left_rgb),  .yuv_o(left_yuv));
  ryp_convert u_conv_right (.rgb_i(right_rgb), .yuv_o(right_yuv));

  // truncated chroma mean of the two pixels
  assign u_pair = {1'b0, left_yuv.u} + {1'b0, right_yuv.u};
  assign v_pair = {1'b0, left_yuv.v} + {1'b0, right_yuv.v};

  assign out_word_d = {left_yuv.y, u_pair[8:1], right_yuv.y, v_pair[8:1]};

  // result register
  always_ff @(posedge clk_i) begin
    if (advance && cap_valid_q) begin
      out_word_q <= out_word_d;
    end
  end

  assign word_o.valid     = out_valid_q;
  assign word_o.yuyv_word = out_word_q;

endmodule
`default_nettype wire

/* rtl/ryp_checker.sv */
`default_nettype none
module ryp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_word_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_word_i))
    else $error("result changed while stalled");

  // an empty output side never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

  // a new result follows an input transfer through the capture and result registers
  a_out_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without matching input transfer");

endmodule

bind rgb_pair_to_yuyv_packer ryp_checker u_ryp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pair_i.valid),
  .in_ready_i  (pair_i.ready),
  .out_valid_i (word_o.valid),
  .out_ready_i (word_o.ready),
  .out_word_i  (word_o.yuyv_word)
);
`default_nettype wire
